// File: src/alpha_weighted_half_downscale_assert.svh
// ----------------------------------------------------------------------------
// alpha weighted half downscale: assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ALPHA_WEIGHTED_HALF_DOWNSCALE_ASSERT_SVH
`define ALPHA_WEIGHTED_HALF_DOWNSCALE_ASSERT_SVH

// same-cycle implication
`define AWHD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AWHD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/awhd_pkg.sv
// ----------------------------------------------------------------------------
// awhd_pkg
// types, constants and helpers shared by the half downscale modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package awhd_pkg;

  // largest source side and derived widths
  localparam int MAX_SRC_SIZE = 128;
  localparam int CNT_W        = $clog2(MAX_SRC_SIZE);
  localparam int SIZE_W       = CNT_W + 1;
  localparam int CMP_W        = (SIZE_W > 8) ? SIZE_W : 8;
  localparam int PIX_W        = 32;

  // arithmetic widths: 4 * 255 * 255 fits 18 bits, 4 * 255 fits 10 bits
  localparam int ACC_W  = 18;
  localparam int ASUM_W = 10;
  localparam int Q_W    = 8;
  localparam int QCNT_W = $clog2(Q_W);

  localparam logic [7:0] SIZE_RESET = 8'd128;

  // accumulator source select
  localparam logic [1:0] SEL_RAM  = 2'd0;
  localparam logic [1:0] SEL_LEFT = 2'd1;
  localparam logic [1:0] SEL_CUR  = 2'd2;

  // input item, red in the low byte
  typedef struct packed {
    logic [7:0] in_alpha;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } awhd_in_t;

  // result item
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       out_last;
  } awhd_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic             ram_we;
    logic [CNT_W-1:0] ram_waddr;
    logic             ram_re;
    logic [CNT_W-1:0] ram_raddr;
    logic             load_left;
    logic             load_cur;
    logic             last;
    logic             acc_clr;
    logic             acc_en;
    logic [1:0]       acc_sel;
    logic             div_init;
    logic             div_step;
  } awhd_cmd_t;

  // last pixel index of a side from the raw size register
  function automatic logic [CNT_W-1:0] last_index(input logic [7:0] raw);
    logic [CMP_W-1:0] s;
    s = CMP_W'(raw & 8'hFE);
    if (s < CMP_W'(2)) s = CMP_W'(2);
    if (s > CMP_W'(MAX_SRC_SIZE)) s = CMP_W'(MAX_SRC_SIZE);
    return CNT_W'(s - CMP_W'(1));
  endfunction

endpackage

// File: src/awhd_ram.sv
// ----------------------------------------------------------------------------
// awhd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awhd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/awhd_datapath.sv
// ----------------------------------------------------------------------------
// awhd_datapath
// line store, block accumulators and restoring dividers for the downscale
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awhd_datapath (
  input  logic                clk,
  input  awhd_pkg::awhd_in_t  in_data,
  input  awhd_pkg::awhd_cmd_t cmd,
  output awhd_pkg::awhd_out_t out_data
);
  import awhd_pkg::*;

  logic [PIX_W-1:0]  ram_rdata;
  awhd_in_t          left_r;
  awhd_in_t          cur_r;
  logic              last_r;
  awhd_in_t          sel_px;
  logic [7:0]        col [3];
  logic [15:0]       prod [3];
  logic [ACC_W-1:0]  acc_r [3];
  logic [ASUM_W-1:0] asum_r;
  logic [ACC_W-1:0]  rem_r [3];
  logic [ACC_W-1:0]  dsr_r;
  logic [Q_W-1:0]    quot_r [3];
  logic              ge [3];
  logic [ACC_W-1:0]  rem_sub [3];

  // even row line store
  awhd_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_SRC_SIZE)
  ) u_row_store (
    .clk  (clk),
    .we   (cmd.ram_we),
    .waddr(cmd.ram_waddr),
    .wdata(in_data),
    .re   (cmd.ram_re),
    .raddr(cmd.ram_raddr),
    .rdata(ram_rdata)
  );

  // held pixels of the odd row
  always_ff @(posedge clk) begin
    if (cmd.load_left) begin
      left_r <= in_data;
    end
    if (cmd.load_cur) begin
      cur_r  <= in_data;
      last_r <= cmd.last;
    end
  end

  // pick the pixel added this cycle
  always_comb begin
    case (cmd.acc_sel)
      SEL_RAM:  sel_px = awhd_in_t'(ram_rdata);
      SEL_LEFT: sel_px = left_r;
      SEL_CUR:  sel_px = cur_r;
      default:  sel_px = cur_r;
    endcase
    col[0] = sel_px.in_red;
    col[1] = sel_px.in_green;
    col[2] = sel_px.in_blue;
    for (int k = 0; k < 3; k++) begin
      prod[k] = 16'(col[k]) * 16'(sel_px.in_alpha);
    end
  end

  // divider compare and subtract per channel
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ge[k]      = rem_r[k] >= dsr_r;
      rem_sub[k] = rem_r[k] - dsr_r;
    end
  end

  // accumulate colour times alpha and the alpha sum, then divide
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      for (int k = 0; k < 3; k++) begin
        acc_r[k] <= '0;
      end
      asum_r <= '0;
    end else if (cmd.acc_en) begin
      for (int k = 0; k < 3; k++) begin
        acc_r[k] <= acc_r[k] + ACC_W'(prod[k]);
      end
      asum_r <= asum_r + ASUM_W'(sel_px.in_alpha);
    end

    if (cmd.div_init) begin
      for (int k = 0; k < 3; k++) begin
        rem_r[k]  <= acc_r[k];
        quot_r[k] <= '0;
      end
      dsr_r <= ACC_W'({asum_r, {(Q_W-1){1'b0}}});
    end else if (cmd.div_step) begin
      for (int k = 0; k < 3; k++) begin
        if (ge[k]) begin
          rem_r[k] <= rem_sub[k];
        end
        quot_r[k] <= {quot_r[k][Q_W-2:0], ge[k]};
      end
      dsr_r <= dsr_r >> 1;
    end
  end

  // result fields, a fully transparent block gives transparent black
  always_comb begin
    out_data.out_red   = (asum_r == '0) ? 8'd0 : quot_r[0];
    out_data.out_green = (asum_r == '0) ? 8'd0 : quot_r[1];
    out_data.out_blue  = (asum_r == '0) ? 8'd0 : quot_r[2];
    out_data.out_alpha = asum_r[ASUM_W-1:2];
    out_data.out_last  = last_r;
  end

endmodule

// File: src/awhd_controller.sv
// ----------------------------------------------------------------------------
// awhd_controller
// raster counters, size register and block sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "alpha_weighted_half_downscale_assert.svh"

module awhd_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  output awhd_pkg::awhd_cmd_t cmd
);
  import awhd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_ACC_B = 3'd2;
  localparam logic [2:0] S_ACC_L = 3'd3;
  localparam logic [2:0] S_ACC_C = 3'd4;
  localparam logic [2:0] S_DINIT = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [QCNT_W-1:0] DIV_LAST = QCNT_W'(Q_W - 1);

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  x_r, x_nxt;
  logic [CNT_W-1:0]  y_r, y_nxt;
  logic [CNT_W-1:0]  xb_r, xb_nxt;
  logic [7:0]        size_r, size_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  lastidx;
  logic [CNT_W-1:0]  xc;
  logic [CNT_W-1:0]  yc;
  logic              in_acc;
  logic              cfg_acc;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // clamp position to the current side
  always_comb begin
    lastidx = last_index(size_r);
    xc      = (x_r > lastidx) ? lastidx : x_r;
    yc      = (y_r > lastidx) ? lastidx : y_r;
  end

  // sequencer and counters
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    xb_nxt    = xb_r;
    size_nxt  = size_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.acc_sel = SEL_RAM;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!yc[0]) begin
            cmd.ram_we    = 1'b1;
            cmd.ram_waddr = xc;
          end else if (!xc[0]) begin
            cmd.load_left = 1'b1;
          end else begin
            cmd.load_cur  = 1'b1;
            cmd.last      = (xc == lastidx) && (yc == lastidx);
            cmd.acc_clr   = 1'b1;
            cmd.ram_re    = 1'b1;
            cmd.ram_raddr = {xc[CNT_W-1:1], 1'b0};
            xb_nxt        = xc;
            state_nxt     = S_RD;
          end
          if (xc == lastidx) begin
            x_nxt = '0;
            y_nxt = (yc == lastidx) ? '0 : yc + 1'b1;
          end else begin
            x_nxt = xc + 1'b1;
            y_nxt = yc;
          end
        end
      end
      S_RD: begin
        cmd.ram_re    = 1'b1;
        cmd.ram_raddr = xb_r;
        cmd.acc_en    = 1'b1;
        state_nxt     = S_ACC_B;
      end
      S_ACC_B: begin
        cmd.acc_en = 1'b1;
        state_nxt  = S_ACC_L;
      end
      S_ACC_L: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = SEL_LEFT;
        state_nxt   = S_ACC_C;
      end
      S_ACC_C: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = SEL_CUR;
        state_nxt   = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // size write restarts the frame
    if (cfg_acc) begin
      size_nxt = cfg_data;
      x_nxt    = '0;
      y_nxt    = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      x_r     <= '0;
      y_r     <= '0;
      xb_r    <= '0;
      size_r  <= SIZE_RESET;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      xb_r    <= xb_nxt;
      size_r  <= size_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // checks
  `AWHD_ASSERT_IMP(a_out_holds_input, out_valid, in_stall, "input taken while result pending")
  `AWHD_ASSERT_NXT(a_plain_item_done, in_acc && !cmd.load_cur, state_r == S_IDLE, "store item not done")
  `AWHD_ASSERT_NXT(a_block_reads_store, in_acc && cmd.load_cur, state_r == S_RD, "block did not start")
  `AWHD_ASSERT_NXT(a_div_ends, state_r == S_DIV && cnt_r == DIV_LAST, out_valid, "divide overran")

endmodule

// File: src/alpha_weighted_half_downscale.sv
// ----------------------------------------------------------------------------
// alpha_weighted_half_downscale
// 2x2 alpha weighted box downscale of a square rgba8 image in raster order
// ----------------------------------------------------------------------------
// usage:
//   in_valid / in_stall / in_data carry source pixels in raster order, an item
//   is taken when in_valid is high and in_stall low. out_valid / out_stall /
//   out_data carry one half size pixel per 2x2 block, out_last on the final one.
//   cfg_valid / cfg_ready / cfg_data write the source side length (bit 0
//   ignored); a write also restarts the frame at row 0, column 0.
// timing:
//   even row pixels and odd row even column pixels do not start a block and leave
//   in_stall low. an odd row odd column pixel runs the block sequence: two line
//   store reads, four accumulate steps, divider load and 8 restoring divide steps,
//   then out_valid rises; in_stall stays high until the result leaves, and the next
//   item can be taken the cycle after that. the 8 step divider loop is the longest
//   part of the sequence.
// reset: counters clear, side length returns to 128, no line store clearing.
// stall: while out_stall is high the result holds and in_stall stays high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alpha_weighted_half_downscale (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  awhd_pkg::awhd_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output awhd_pkg::awhd_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import awhd_pkg::*;

  awhd_cmd_t cmd;

  // sequencer
  awhd_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd)
  );

  // store and arithmetic
  awhd_datapath u_dp (
    .clk     (clk),
    .in_data (in_data),
    .cmd     (cmd),
    .out_data(out_data)
  );

endmodule
